// File: hw/rtl/assert_macros.svh
// assertion helpers, clocked on clk
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define RPCD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked in reset too
`define RPCD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/rpcd_pkg.sv
`default_nettype none

package rpcd_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_START_CODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REG_MASK   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN    = 2'd2;

  localparam logic [15:0] MAX_LEN_RESET = 16'd256;

  localparam logic [1:0] EV_DATA   = 2'd0;
  localparam logic [1:0] EV_OK     = 2'd1;
  localparam logic [1:0] EV_CSUM   = 2'd2;
  localparam logic [1:0] EV_NOFUNC = 2'd3;

  typedef enum logic [1:0] {
    CMD_DATA,
    CMD_HDR_BAD,
    CMD_CALL_END
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [4:0]  index;
    logic [15:0] length;
    logic [7:0]  data;
    logic        last;
    logic [15:0] sum_calc;
    logic [15:0] sum_recv;
  } cmd_t;

endpackage

`default_nettype wire

// File: hw/rtl/rpcd_if.sv
`default_nettype none

interface rpcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface rpcd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_res;
  logic [4:0]  call_index;
  logic [15:0] payload_length;
  logic [7:0]  data_byte;
  logic        last;

  modport source (output valid, output event_res, output call_index,
                  output payload_length, output data_byte, output last, input ready);
  modport sink (input valid, input event_res, input call_index,
                input payload_length, input data_byte, input last, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/rpcd_fifo.sv
`default_nettype none

module rpcd_fifo #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rpcd_pkg::cmd_t push_cmd,
  input  logic          pop,
  output rpcd_pkg::cmd_t pop_cmd,
  output logic          full,
  output logic          empty
);
  import rpcd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cmd_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_FULL);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    priority if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end else begin
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/rpcd_front.sv
`default_nettype none

module rpcd_front #(
  parameter int TABLE_ENTRIES = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  rpcd_in_if.sink        in_chan,
  input  logic [31:0]    start_code,
  input  logic [15:0]    max_data_len,
  input  logic           q_full,
  output logic           q_push,
  output rpcd_pkg::cmd_t q_cmd
);
  import rpcd_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_HDR,
    PH_HSUM,
    PH_DATA,
    PH_DSUM
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [31:0] window_r, window_nxt;
  logic [15:0] count_r, count_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [7:0]  rx_lo_r, rx_lo_nxt;
  logic [7:0]  index_r, index_nxt;
  logic [15:0] length_r, length_nxt;

  logic        take;
  logic [7:0]  b;
  logic [15:0] sum_add;
  logic [15:0] sum_recv;
  logic [15:0] count_inc;
  logic        is_last;

  assign in_chan.ready = !q_full;
  assign take      = in_chan.valid && !q_full;
  assign b         = in_chan.rx_byte;
  assign sum_add   = sum_r + {8'd0, b};
  assign sum_recv  = {b, rx_lo_r};
  assign count_inc = count_r + 16'd1;
  assign is_last   = (count_inc >= length_r);

  always_comb begin
    phase_nxt  = phase_r;
    window_nxt = window_r;
    count_nxt  = count_r;
    sum_nxt    = sum_r;
    rx_lo_nxt  = rx_lo_r;
    index_nxt  = index_r;
    length_nxt = length_r;
    q_push     = 1'b0;
    q_cmd.kind     = CMD_DATA;
    q_cmd.index    = index_r[4:0];
    q_cmd.length   = length_r;
    q_cmd.data     = 8'd0;
    q_cmd.last     = 1'b0;
    q_cmd.sum_calc = sum_r;
    q_cmd.sum_recv = sum_recv;
    if (take) begin
      unique case (phase_r)
        PH_HUNT: begin
          window_nxt = {b, window_r[31:8]};
          if (window_nxt == start_code) begin
            phase_nxt = PH_HDR;
            count_nxt = '0;
            sum_nxt   = '0;
            rx_lo_nxt = '0;
          end
        end
        PH_HDR: begin
          sum_nxt = sum_add;
          priority case (count_r[1:0])
            2'd0: index_nxt = b;
            2'd1: length_nxt = {length_r[15:8], b};
            default: length_nxt = {b, length_r[7:0]};
          endcase
          if (count_r[1:0] == 2'd2) begin
            phase_nxt = PH_HSUM;
            count_nxt = '0;
          end else begin
            count_nxt = count_inc;
          end
        end
        PH_HSUM: begin
          if (count_r == '0) begin
            rx_lo_nxt = b;
            count_nxt = 16'd1;
          end else begin
            priority if (sum_recv != sum_r) begin
              q_push     = 1'b1;
              q_cmd.kind = CMD_HDR_BAD;
              phase_nxt  = PH_HUNT;
            end else if (index_r >= 8'(TABLE_ENTRIES) || length_r > max_data_len) begin
              phase_nxt = PH_HUNT;
            end else begin
              phase_nxt = (length_r == '0) ? PH_DSUM : PH_DATA;
            end
            window_nxt = '0;
            count_nxt  = '0;
            sum_nxt    = '0;
            rx_lo_nxt  = '0;
          end
        end
        PH_DATA: begin
          sum_nxt    = sum_add;
          q_push     = 1'b1;
          q_cmd.kind = CMD_DATA;
          q_cmd.data = b;
          q_cmd.last = is_last;
          if (is_last) begin
            phase_nxt = PH_DSUM;
            count_nxt = '0;
          end else begin
            count_nxt = count_inc;
          end
        end
        PH_DSUM: begin
          if (count_r == '0) begin
            rx_lo_nxt = b;
            count_nxt = 16'd1;
          end else begin
            q_push     = 1'b1;
            q_cmd.kind = CMD_CALL_END;
            phase_nxt  = PH_HUNT;
            window_nxt = '0;
            count_nxt  = '0;
            sum_nxt    = '0;
            rx_lo_nxt  = '0;
          end
        end
        default: begin
          phase_nxt  = PH_HUNT;
          window_nxt = '0;
          count_nxt  = '0;
          sum_nxt    = '0;
          rx_lo_nxt  = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      window_r <= '0;
      count_r  <= '0;
      sum_r    <= '0;
      rx_lo_r  <= '0;
      index_r  <= '0;
      length_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      window_r <= window_nxt;
      count_r  <= count_nxt;
      sum_r    <= sum_nxt;
      rx_lo_r  <= rx_lo_nxt;
      index_r  <= index_nxt;
      length_r <= length_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/rpcd_back.sv
`default_nettype none

module rpcd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [31:0]    registered_mask,
  input  logic           q_empty,
  input  rpcd_pkg::cmd_t q_cmd,
  output logic           q_pop,
  rpcd_out_if.source     out_chan
);
  import rpcd_pkg::*;

  logic        out_valid_r;
  logic [1:0]  event_r, event_nxt;
  logic [4:0]  index_r;
  logic [15:0] length_r;
  logic [7:0]  data_r;
  logic        last_r;

  assign q_pop = !q_empty && (!out_valid_r || out_chan.ready);

  // resolve the event code of each queued command, including the end-of-call report
  always_comb begin
    unique case (q_cmd.kind)
      CMD_DATA:    event_nxt = EV_DATA;
      CMD_HDR_BAD: event_nxt = EV_CSUM;
      CMD_CALL_END: begin
        priority if (q_cmd.sum_calc != q_cmd.sum_recv) begin
          event_nxt = EV_CSUM;
        end else if (registered_mask[q_cmd.index]) begin
          event_nxt = EV_OK;
        end else begin
          event_nxt = EV_NOFUNC;
        end
      end
      default: event_nxt = EV_CSUM;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      event_r  <= event_nxt;
      index_r  <= q_cmd.index;
      length_r <= q_cmd.length;
      data_r   <= (q_cmd.kind == CMD_DATA) ? q_cmd.data : 8'd0;
      last_r   <= (q_cmd.kind == CMD_DATA) && q_cmd.last;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.event_res      = event_r;
  assign out_chan.call_index     = index_r;
  assign out_chan.payload_length = length_r;
  assign out_chan.data_byte      = data_r;
  assign out_chan.last           = last_r;

endmodule

`default_nettype wire

// File: hw/rtl/rpc_request_deframer.sv
// Receive-side call deframer: takes one link byte per request, hunts for the
// configured 32-bit start code (lowest byte first), checks the three-byte call
// header against its 16-bit additive checksum, passes payload bytes through
// with the final one flagged and ends each call with a single report: ok,
// checksum error or unregistered function. Bad index or oversize length drops
// back to hunting silently. A new byte is taken every cycle while the queue is
// not full; the parser state is registered and updates once per byte taken.
// Results go through a 4-entry queue and an output register, and the input
// only stalls once the queue fills behind a stalled output. No clearing pass
// after reset. Configuration is to be written only while idle; the block
// itself does not enforce this.
`default_nettype none

module rpc_request_deframer #(
  parameter int TABLE_ENTRIES = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  rpcd_in_if.sink                               in_chan,
  rpcd_out_if.source                            out_chan,
  input  logic                                  cfg_we,
  input  logic [rpcd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rpcd_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
  import rpcd_pkg::*;

  localparam int QUEUE_DEPTH = 4;

  logic [31:0] start_code_r;
  logic [31:0] reg_mask_r;
  logic [15:0] max_len_r;

  logic q_push, q_pop, q_full, q_empty;
  cmd_t q_in, q_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_code_r <= '0;
      reg_mask_r   <= '0;
      max_len_r    <= MAX_LEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_CODE: start_code_r <= cfg_wdata[31:0];
        CFG_REG_MASK:   reg_mask_r   <= cfg_wdata[31:0];
        CFG_MAX_LEN:    max_len_r    <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  rpcd_front #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_chan      (in_chan),
    .start_code   (start_code_r),
    .max_data_len (max_len_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (q_in)
  );

  rpcd_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_in),
    .pop      (q_pop),
    .pop_cmd  (q_out),
    .full     (q_full),
    .empty    (q_empty)
  );

  rpcd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .registered_mask (reg_mask_r),
    .q_empty         (q_empty),
    .q_cmd           (q_out),
    .q_pop           (q_pop),
    .out_chan        (out_chan)
  );

endmodule

`default_nettype wire

// File: hw/rtl/rpcd_checker.sv
`default_nettype none
`include "assert_macros.svh"

module rpcd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_event_res,
  input logic [4:0]  out_call_index,
  input logic [15:0] out_payload_length,
  input logic [7:0]  out_data_byte,
  input logic        out_last
);
  import rpcd_pkg::*;

  `RPCD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_event_res) && $stable(out_call_index) && $stable(out_payload_length) && $stable(out_data_byte) && $stable(out_last), "stalled request changed")
  `RPCD_ASSERT(a_report_no_data, out_valid && out_event_res != EV_DATA |-> out_data_byte == 8'd0, "report carries a data byte")
  `RPCD_ASSERT(a_last_is_data, out_valid && out_last |-> out_event_res == EV_DATA, "last flag on a report")
  `RPCD_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid, "output valid right after reset")

endmodule

bind rpc_request_deframer rpcd_checker u_rpcd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_chan.valid),
  .out_ready          (out_chan.ready),
  .out_event_res      (out_chan.event_res),
  .out_call_index     (out_chan.call_index),
  .out_payload_length (out_chan.payload_length),
  .out_data_byte      (out_chan.data_byte),
  .out_last           (out_chan.last)
);

`default_nettype wire

// File: test/rpc_request_deframer_tb.sv
`default_nettype none

module rpc_request_deframer_tb;
  import rpcd_pkg::*;

  localparam int TABLE_ENTRIES = 32;
  localparam int HOLD_CYCLES   = 300;

  typedef enum logic [2:0] {
    PARSE_HUNT,
    PARSE_HDR,
    PARSE_HSUM,
    PARSE_DATA,
    PARSE_DSUM
  } parse_t;

  typedef struct packed {
    logic [1:0]  ev;
    logic [4:0]  idx;
    logic [15:0] len;
    logic [7:0]  data;
    logic        last;
  } report_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  rpcd_in_if  in_bus ();
  rpcd_out_if out_bus ();

  rpc_request_deframer #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // register copies
  logic [31:0] cfg_code;
  logic [31:0] cfg_mask;
  logic [15:0] cfg_maxlen;

  // deframer state copy
  logic [31:0] scan_win;
  parse_t      parse_st;
  logic [15:0] field_cnt;
  logic [15:0] sum_run;
  logic [15:0] sum_got;
  logic [7:0]  hdr_index;
  logic [15:0] hdr_len;

  logic [7:0] link_bytes[$];
  report_t    pending_reports[$];

  int  bytes_queued;
  int  bytes_taken;
  int  reports_checked;
  int  frames_built;
  int  settings_used;
  int  fail_count;
  int  in_gap;
  int  ready_gap;
  int  stall_left;
  int  hold_req;
  int  hold_seen;
  bit  no_idle;
  bit  in_fire;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 88) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  function automatic void restart_hunt();
    parse_st  = PARSE_HUNT;
    scan_win  = '0;
    field_cnt = '0;
    sum_run   = '0;
    sum_got   = '0;
  endfunction

  function automatic void post_report(input logic [1:0] ev, input logic [7:0] data,
                                      input logic last);
    report_t r;
    r.ev   = ev;
    r.idx  = hdr_index[4:0];
    r.len  = hdr_len;
    r.data = data;
    r.last = last;
    pending_reports.push_back(r);
  endfunction

  function automatic void step_deframer(input logic [7:0] b);
    logic lst;
    case (parse_st)
      PARSE_HUNT: begin
        scan_win = {b, scan_win[31:8]};
        if (scan_win == cfg_code) begin
          parse_st  = PARSE_HDR;
          field_cnt = '0;
          sum_run   = '0;
          sum_got   = '0;
        end
      end
      PARSE_HDR: begin
        sum_run = sum_run + 16'(b);
        if (field_cnt == 16'd0) hdr_index = b;
        else if (field_cnt == 16'd1) hdr_len[7:0] = b;
        else hdr_len[15:8] = b;
        field_cnt = field_cnt + 16'd1;
        if (field_cnt >= 16'd3) begin
          parse_st  = PARSE_HSUM;
          field_cnt = '0;
        end
      end
      PARSE_HSUM: begin
        if (field_cnt == 16'd0) begin
          sum_got   = {8'h00, b};
          field_cnt = 16'd1;
        end else begin
          sum_got = sum_got | {b, 8'h00};
          if (sum_got != sum_run) begin
            post_report(EV_CSUM, 8'h00, 1'b0);
            restart_hunt();
          end else if (hdr_index >= TABLE_ENTRIES || hdr_len > cfg_maxlen) begin
            restart_hunt();
          end else begin
            sum_run   = '0;
            sum_got   = '0;
            field_cnt = '0;
            parse_st  = (hdr_len == 16'd0) ? PARSE_DSUM : PARSE_DATA;
          end
        end
      end
      PARSE_DATA: begin
        sum_run   = sum_run + 16'(b);
        field_cnt = field_cnt + 16'd1;
        lst       = (field_cnt >= hdr_len);
        post_report(EV_DATA, b, lst);
        if (lst) begin
          parse_st  = PARSE_DSUM;
          field_cnt = '0;
        end
      end
      PARSE_DSUM: begin
        if (field_cnt == 16'd0) begin
          sum_got   = {8'h00, b};
          field_cnt = 16'd1;
        end else begin
          sum_got = sum_got | {b, 8'h00};
          if (sum_got != sum_run) post_report(EV_CSUM, 8'h00, 1'b0);
          else if (cfg_mask[hdr_index[4:0]]) post_report(EV_OK, 8'h00, 1'b0);
          else post_report(EV_NOFUNC, 8'h00, 1'b0);
          restart_hunt();
        end
      end
      default: restart_hunt();
    endcase
  endfunction

  function automatic void feed(input logic [7:0] b);
    link_bytes.push_back(b);
    bytes_queued++;
  endfunction

  // start code (stopping once the window matches), header, then payload unless dropped
  function automatic void add_frame(input logic [7:0] idx, input logic [15:0] len,
                                    input bit bad_hdr, input bit bad_data, input bit cut);
    logic [7:0]  fr[$];
    logic [31:0] win;
    logic [15:0] hsum;
    logic [15:0] dsum;
    logic [7:0]  b;
    int          keep;
    win = '0;
    for (int k = 0; k < 4; k++) begin
      b   = cfg_code[8*k +: 8];
      win = {b, win[31:8]};
      fr.push_back(b);
      if (win == cfg_code) break;
    end
    hsum = 16'(idx) + 16'(len[7:0]) + 16'(len[15:8]);
    if (bad_hdr) hsum ^= 16'(1 << $urandom_range(0, 15));
    fr.push_back(idx);
    fr.push_back(len[7:0]);
    fr.push_back(len[15:8]);
    fr.push_back(hsum[7:0]);
    fr.push_back(hsum[15:8]);
    if (!bad_hdr && idx < TABLE_ENTRIES && len <= cfg_maxlen) begin
      dsum = '0;
      for (int k = 0; k < int'(len); k++) begin
        if ($urandom_range(0, 9) == 0) b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        else b = 8'($urandom);
        dsum += 16'(b);
        fr.push_back(b);
      end
      if (bad_data) dsum ^= 16'(1 << $urandom_range(0, 15));
      fr.push_back(dsum[7:0]);
      fr.push_back(dsum[15:8]);
    end
    keep = cut ? $urandom_range(1, fr.size() - 1) : fr.size();
    for (int k = 0; k < keep; k++) feed(fr[k]);
    frames_built++;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_START_CODE: cfg_code = value;
      CFG_REG_MASK:   cfg_mask = value;
      CFG_MAX_LEN:    cfg_maxlen = value[15:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [31:0] code, input logic [31:0] mask,
                                input logic [15:0] maxlen);
    write_reg(CFG_START_CODE, code);
    write_reg(CFG_REG_MASK, mask);
    write_reg(CFG_MAX_LEN, {16'h0000, maxlen});
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic wait_quiet();
    while (bytes_taken != bytes_queued || pending_reports.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  // request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_fire) begin
      if (in_gap > 0 && !no_idle) begin
        in_gap = in_gap - 1;
        in_bus.valid <= 1'b0;
      end else if (link_bytes.size() > 0) begin
        in_bus.rx_byte <= link_bytes.pop_front();
        in_bus.valid   <= 1'b1;
        in_gap = pick_gap();
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // report receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen  = hold_req;
      stall_left = HOLD_CYCLES;
      out_bus.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_bus.ready <= 1'b0;
    end else if (no_idle) begin
      out_bus.ready <= 1'b1;
    end else if (ready_gap > 0) begin
      ready_gap = ready_gap - 1;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) ready_gap = pick_gap();
    end
  end

  always @(posedge clk) begin : monitor
    report_t want;
    in_fire <= rst_n && in_bus.valid && in_bus.ready;
    if (rst_n && in_bus.valid && in_bus.ready) begin
      step_deframer(in_bus.rx_byte);
      bytes_taken++;
    end
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_reports.size() == 0) begin
        $error("report with none pending: event_res %0d call_index %0d data_byte %0h",
               out_bus.event_res, out_bus.call_index, out_bus.data_byte);
        fail_count++;
      end else begin
        want = pending_reports.pop_front();
        reports_checked++;
        if (out_bus.event_res !== want.ev) begin
          $error("event_res expected %0d actual %0d", want.ev, out_bus.event_res);
          fail_count++;
        end
        if (out_bus.call_index !== want.idx) begin
          $error("call_index expected %0d actual %0d", want.idx, out_bus.call_index);
          fail_count++;
        end
        if (out_bus.payload_length !== want.len) begin
          $error("payload_length expected %0d actual %0d", want.len, out_bus.payload_length);
          fail_count++;
        end
        if (out_bus.data_byte !== want.data) begin
          $error("data_byte expected %0h actual %0h", want.data, out_bus.data_byte);
          fail_count++;
        end
        if (out_bus.last !== want.last) begin
          $error("last expected %0d actual %0d", want.last, out_bus.last);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #10000000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int          phase_start;
    int          pick;
    int          lim;
    logic [7:0]  idx;
    logic [15:0] len;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    in_bus.valid   = 1'b0;
    in_bus.rx_byte = '0;
    out_bus.ready  = 1'b0;
    in_fire        = 1'b0;
    no_idle        = 1'b0;
    cfg_code       = '0;
    cfg_mask       = '0;
    cfg_maxlen     = MAX_LEN_RESET;
    hdr_index      = '0;
    hdr_len        = '0;
    restart_hunt();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset values: zero start code, nothing registered
    add_frame(8'd0, 16'd0, 1'b0, 1'b0, 1'b0);
    add_frame(8'd3, 16'd2, 1'b0, 1'b0, 1'b0);
    wait_quiet();

    apply_settings(32'h0000_0000, 32'h8000_0001, 16'd4);
    add_frame(8'd0, 16'd1, 1'b0, 1'b0, 1'b0);
    add_frame(8'd31, 16'd4, 1'b0, 1'b0, 1'b0);
    add_frame(8'd5, 16'd2, 1'b0, 1'b0, 1'b0);
    add_frame(8'd0, 16'd1, 1'b1, 1'b0, 1'b0);
    add_frame(8'hFF, 16'd1, 1'b0, 1'b0, 1'b0);
    add_frame(8'd0, 16'd5, 1'b0, 1'b0, 1'b0);
    add_frame(8'd31, 16'd2, 1'b0, 1'b1, 1'b0);
    add_frame(8'd31, 16'd0, 1'b0, 1'b0, 1'b0);
    wait_quiet();

    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        1: apply_settings(32'h0000_0000, 32'h0000_0000, 16'd0);
        2: apply_settings($urandom, 32'h8000_0001, 16'd1);
        3: apply_settings($urandom, $urandom, 16'd24);
        default: apply_settings($urandom, $urandom, 16'($urandom_range(0, 40)));
      endcase
      no_idle = (ph == 0) || (ph == 2);
      if (ph == 0) begin
        // long payload while the receiver holds off
        hold_req++;
        add_frame(8'd7, 16'd48, 1'b0, 1'b0, 1'b0);
      end
      phase_start = bytes_queued;
      while (bytes_queued - phase_start < 140) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          repeat ($urandom_range(1, 6)) feed(8'($urandom));
        end else begin
          if ($urandom_range(0, 9) == 0) idx = $urandom_range(0, 1) ? 8'd31 : 8'd0;
          else idx = 8'($urandom_range(0, TABLE_ENTRIES - 1));
          lim = (cfg_maxlen < 16'd24) ? int'(cfg_maxlen) : 24;
          len = 16'($urandom_range(0, lim));
          if ($urandom_range(0, 19) == 0 && cfg_maxlen <= 16'd64) len = cfg_maxlen;
          if (pick < 13 && cfg_maxlen < 16'hFFFF) begin
            len = ($urandom_range(0, 3) == 0) ? 16'hFFFF : cfg_maxlen + 16'd1;
          end else if (pick < 18) begin
            idx = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(TABLE_ENTRIES, 255));
          end
          add_frame(idx, len, pick >= 18 && pick < 26, pick >= 26 && pick < 32,
                    pick >= 32 && pick < 35);
        end
      end
      wait_quiet();
      no_idle = 1'b0;
    end

    $display("covered %0d link bytes in %0d frames under %0d register settings",
             bytes_taken, frames_built, settings_used);
    $display("checked %0d reports, %0d mismatches", reports_checked, fail_count);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
+incdir+hw/rtl
hw/rtl/rpcd_pkg.sv
hw/rtl/rpcd_if.sv
hw/rtl/rpcd_fifo.sv
hw/rtl/rpcd_front.sv
hw/rtl/rpcd_back.sv
hw/rtl/rpc_request_deframer.sv
hw/rtl/rpcd_checker.sv
test/rpc_request_deframer_tb.sv
